>>> rtl/delimited_text_field_splitter_macros.svh
// Assertion helpers shared by the splitter modules.
// Each expects clk and rst_n to be in scope.
`ifndef DELIMITED_TEXT_FIELD_SPLITTER_MACROS_SVH
`define DELIMITED_TEXT_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication.
`define DTFS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("splitter check failed: same-cycle implication");

// Next-cycle implication.
`define DTFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("splitter check failed: next-cycle implication");

`endif

>>> rtl/dtfs_pkg.sv
package dtfs_pkg;

  localparam int MAX_COLUMNS = 16;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  localparam logic [7:0]  DELIM_RESET     = 8'd44;
  localparam logic [4:0]  COLS_RESET      = 5'd16;
  localparam logic [31:0] ROW_LIMIT_RESET = 32'd0;

  typedef enum logic [1:0] {
    CFG_DELIMITER    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_ROW_LIMIT    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    EV_FIELD_BYTE = 2'd0,
    EV_FIELD_END  = 2'd1,
    EV_PAD        = 2'd2,
    EV_ROW_END    = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  column;
    logic [7:0]  value_byte;
    logic [31:0] row_index;
    logic        limit_reached;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CR,
    ST_BYTE,
    ST_FEND,
    ST_PAD,
    ST_ROW,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LF,
    OP_CR,
    OP_BYTE,
    OP_FEND,
    OP_PAD,
    OP_ROW,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic emit;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic byte_lf;
    logic byte_cr;
    logic eof;
    logic halted;
    logic cr_held;
    logic line_content;
    logic fp_lt_cols;
    logic fp1_lt_cols;
    logic cr_is_delim;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/delimited_text_field_splitter.sv
// Flow: each transfer is latched in the idle state and then passes a CR check state; a field
// byte is registered into the output in the byte state, a released CR in the CR check state.
// A newline's results are registered from the field-end state on, through the pad and row-end
// states as needed. A new byte is taken only in the idle state, so one byte is handled at a time;
// a final byte adds its line end and a clearing state, and output stalls hold the controller.
// Reset: synchronous rst_n clears the parse state and restores the register defaults.
module delimited_text_field_splitter
  import dtfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  dtfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtfs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> rtl/dtfs_ctrl.sv
`include "delimited_text_field_splitter_macros.svh"

module dtfs_ctrl
  import dtfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_t finish;
    logic   emit;
    logic   byte_follows;
    finish       = sts.eof ? ST_FIN : ST_IDLE;
    emit         = 1'b0;
    byte_follows = 1'b0;
    state_nxt    = state_r;
    in_stall     = 1'b1;
    cmd          = '{op: OP_NONE, emit: 1'b0, last: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_CR;
        end
      end
      ST_CR: begin
        if (sts.halted) begin
          state_nxt = finish;
        end else if (sts.byte_lf) begin
          cmd.op    = OP_LF;
          state_nxt = ST_FEND;
        end else if (sts.cr_held) begin
          // The released CR is last only if the byte itself emits nothing
          // and no end of line follows.
          emit         = sts.fp_lt_cols;
          byte_follows = !sts.byte_cr &&
                         (sts.cr_is_delim ? sts.fp1_lt_cols : sts.fp_lt_cols);
          if (!emit || sts.out_free) begin
            cmd.op    = OP_CR;
            cmd.emit  = emit;
            cmd.last  = !sts.eof && !byte_follows;
            state_nxt = ST_BYTE;
          end
        end else begin
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        emit = !sts.byte_cr && sts.fp_lt_cols;
        if (!emit || sts.out_free) begin
          cmd.op    = OP_BYTE;
          cmd.emit  = emit;
          cmd.last  = !sts.eof;
          state_nxt = sts.eof ? ST_FEND : ST_IDLE;
        end
      end
      ST_FEND: begin
        if (!sts.line_content) begin
          state_nxt = finish;
        end else if (!sts.fp_lt_cols) begin
          state_nxt = ST_ROW;
        end else if (sts.out_free) begin
          cmd.op    = OP_FEND;
          cmd.emit  = 1'b1;
          state_nxt = sts.fp1_lt_cols ? ST_PAD : ST_ROW;
        end
      end
      ST_PAD: begin
        if (sts.out_free) begin
          cmd.op    = OP_PAD;
          cmd.emit  = 1'b1;
          state_nxt = sts.fp1_lt_cols ? ST_PAD : ST_ROW;
        end
      end
      ST_ROW: begin
        if (sts.out_free) begin
          cmd.op    = OP_ROW;
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = finish;
        end
      end
      ST_FIN: begin
        cmd.op    = OP_CLEAR;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `DTFS_ASSERT_IMP(a_pad_in_range, state_r == ST_PAD, sts.fp_lt_cols)
  `DTFS_ASSERT_IMP(a_row_has_content, state_r == ST_ROW, sts.line_content)
  `DTFS_ASSERT_IMP(a_emit_into_free_slot, cmd.emit, sts.out_free)

endmodule

>>> rtl/dtfs_datapath.sv
`include "delimited_text_field_splitter_macros.svh"

module dtfs_datapath
  import dtfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  localparam logic [6:0] MAX_COLS_W = 7'(MAX_COLUMNS);

  logic [7:0]  delim_r;
  logic [4:0]  cols_cfg_r;
  logic [31:0] row_limit_r;

  logic [7:0]  byte_r;
  logic        eof_r;

  logic [4:0]  fp_r, fp_nxt;
  logic        lhc_r, lhc_nxt;
  logic        crh_r, crh_nxt;
  logic [31:0] rows_r, rows_nxt;
  logic        halted_r, halted_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r;
  out_item_t   ev;

  logic [4:0]  eff_cols;
  logic        fp_lt_cols;
  logic        fp1_lt_cols;
  logic        row_lim;
  logic [7:0]  content_byte;
  logic        content_delim;

  // Column count outside its range is clamped to one or to the maximum.
  always_comb begin
    if (cols_cfg_r == 5'd0) begin
      eff_cols = 5'd1;
    end else if (7'(cols_cfg_r) > MAX_COLS_W) begin
      eff_cols = MAX_COLS_W[4:0];
    end else begin
      eff_cols = cols_cfg_r;
    end
  end

  assign fp_lt_cols    = fp_r < eff_cols;
  assign fp1_lt_cols   = (6'(fp_r) + 6'd1) < 6'(eff_cols);
  assign row_lim       = (row_limit_r != 32'd0) && ((rows_r + 32'd1) == row_limit_r);
  assign content_byte  = (cmd.op == OP_CR) ? BYTE_CR : byte_r;
  assign content_delim = content_byte == delim_r;

  assign sts.byte_lf      = byte_r == BYTE_LF;
  assign sts.byte_cr      = byte_r == BYTE_CR;
  assign sts.eof          = eof_r;
  assign sts.halted       = halted_r;
  assign sts.cr_held      = crh_r;
  assign sts.line_content = lhc_r;
  assign sts.fp_lt_cols   = fp_lt_cols;
  assign sts.fp1_lt_cols  = fp1_lt_cols;
  assign sts.cr_is_delim  = delim_r == BYTE_CR;
  assign sts.out_free     = !out_valid_r || !out_stall;

  always_comb begin
    fp_nxt           = fp_r;
    lhc_nxt          = lhc_r;
    crh_nxt          = crh_r;
    rows_nxt         = rows_r;
    halted_nxt       = halted_r;
    ev               = '0;
    ev.column        = fp_r[3:0];
    ev.row_index     = rows_r;
    ev.last_of_run   = cmd.last;
    unique case (cmd.op) inside
      OP_NONE, OP_LATCH: begin
      end
      OP_LF: begin
        crh_nxt = 1'b0;
      end
      OP_CR, OP_BYTE: begin
        if (cmd.op == OP_CR) begin
          crh_nxt = 1'b0;
        end else begin
          // A CR that is the final byte of the file is dropped at once.
          crh_nxt = sts.byte_cr && !eof_r;
        end
        if (cmd.op == OP_CR || !sts.byte_cr) begin
          lhc_nxt = 1'b1;
          if (content_delim) begin
            ev.event_kind = EV_FIELD_END;
            if (fp_lt_cols) begin
              fp_nxt = fp_r + 5'd1;
            end
          end else begin
            ev.event_kind = EV_FIELD_BYTE;
            ev.value_byte = content_byte;
          end
        end
      end
      OP_FEND: begin
        ev.event_kind = EV_FIELD_END;
        fp_nxt        = fp_r + 5'd1;
      end
      OP_PAD: begin
        ev.event_kind = EV_PAD;
        fp_nxt        = fp_r + 5'd1;
      end
      OP_ROW: begin
        ev.event_kind    = EV_ROW_END;
        ev.column        = 4'd0;
        ev.limit_reached = row_lim;
        rows_nxt         = rows_r + 32'd1;
        halted_nxt       = halted_r || row_lim;
        fp_nxt           = 5'd0;
        lhc_nxt          = 1'b0;
      end
      OP_CLEAR: begin
        fp_nxt     = 5'd0;
        lhc_nxt    = 1'b0;
        crh_nxt    = 1'b0;
        rows_nxt   = 32'd0;
        halted_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r     <= DELIM_RESET;
      cols_cfg_r  <= COLS_RESET;
      row_limit_r <= ROW_LIMIT_RESET;
      fp_r        <= 5'd0;
      lhc_r       <= 1'b0;
      crh_r       <= 1'b0;
      rows_r      <= 32'd0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DELIMITER:    delim_r     <= cfg_wdata[7:0];
          CFG_COLUMN_COUNT: cols_cfg_r  <= cfg_wdata[4:0];
          CFG_ROW_LIMIT:    row_limit_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      fp_r        <= fp_nxt;
      lhc_r       <= lhc_nxt;
      crh_r       <= crh_nxt;
      rows_r      <= rows_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      byte_r <= in_item.text_byte;
      eof_r  <= in_item.end_of_file;
    end
    if (cmd.emit) begin
      out_r <= ev;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `DTFS_ASSERT_NXT(a_limit_halts, cmd.op == OP_ROW && row_lim, halted_r)

endmodule

>>> sim/delimited_text_field_splitter_test.sv
module delimited_text_field_splitter_test;
  import dtfs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_DELIMITER;
  logic [31:0] cfg_wdata = '0;

  delimited_text_field_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Register copies and parse state of the splitter, as the testbench sees them.
  logic [7:0]  cfg_delim;
  logic [4:0]  cfg_cols;
  logic [31:0] cfg_row_limit;
  int unsigned field_pos;
  bit          line_busy;
  bit          cr_pending;
  logic [31:0] rows_emitted;
  bit          stopped;

  out_item_t   step_events[$];
  out_item_t   expected_events[$];
  logic [7:0]  file_text[$];
  int unsigned sent_bytes = 0;
  int unsigned mismatch_count = 0;
  bit          idle_on = 1'b0;
  int unsigned stall_left = 0;

  function void clear_parse();
    field_pos = 0;
    line_busy = 1'b0;
    cr_pending = 1'b0;
    rows_emitted = '0;
    stopped = 1'b0;
  endfunction

  function void reset_splitter_copy();
    cfg_delim = DELIM_RESET;
    cfg_cols = COLS_RESET;
    cfg_row_limit = ROW_LIMIT_RESET;
    clear_parse();
  endfunction

  function int unsigned live_columns();
    if (cfg_cols == 5'd0) return 1;
    if (cfg_cols > MAX_COLUMNS) return MAX_COLUMNS;
    return cfg_cols;
  endfunction

  function void note_event(event_kind_t kind, logic [3:0] col, logic [7:0] val, logic lim);
    out_item_t ev;
    ev.event_kind = kind;
    ev.column = col;
    ev.value_byte = val;
    ev.row_index = rows_emitted;
    ev.limit_reached = lim;
    ev.last_of_run = 1'b0;
    step_events.insert(step_events.size(), ev);
  endfunction

  function void append_text(logic [7:0] c);
    file_text.insert(file_text.size(), c);
  endfunction

  function void take_text(logic [7:0] c);
    line_busy = 1'b1;
    if (field_pos < live_columns()) begin
      if (c == cfg_delim) begin
        note_event(EV_FIELD_END, 4'(field_pos), 8'd0, 1'b0);
        field_pos++;
      end else begin
        note_event(EV_FIELD_BYTE, 4'(field_pos), c, 1'b0);
      end
    end
  endfunction

  function void close_line();
    int unsigned k;
    logic lim;
    if (!line_busy) return;
    if (field_pos < live_columns()) begin
      note_event(EV_FIELD_END, 4'(field_pos), 8'd0, 1'b0);
      for (k = field_pos + 1; k < live_columns(); k++)
        note_event(EV_PAD, 4'(k), 8'd0, 1'b0);
    end
    lim = (cfg_row_limit != 32'd0) && (rows_emitted + 32'd1 == cfg_row_limit);
    note_event(EV_ROW_END, 4'd0, 8'd0, lim);
    rows_emitted = rows_emitted + 32'd1;
    if (lim) stopped = 1'b1;
    field_pos = 0;
    line_busy = 1'b0;
  endfunction

  // Works out the events one accepted byte causes and queues them in order.
  function void predict_split(in_item_t it);
    step_events.delete();
    if (!stopped) begin
      if (it.text_byte == BYTE_LF) begin
        cr_pending = 1'b0;
        close_line();
      end else begin
        // A held CR that is not followed by a newline turns into plain content.
        if (cr_pending) begin
          cr_pending = 1'b0;
          take_text(BYTE_CR);
        end
        if (it.text_byte == BYTE_CR) cr_pending = 1'b1;
        else take_text(it.text_byte);
        if (it.end_of_file) begin
          cr_pending = 1'b0;
          close_line();
        end
      end
    end
    if (it.end_of_file) clear_parse();
    if (step_events.size() > 0) step_events[step_events.size() - 1].last_of_run = 1'b1;
    expected_events = {expected_events, step_events};
  endfunction

  function int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function void report_field(string name, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_item);
        mismatch_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_item.event_kind !== want.event_kind)
          report_field("event_kind", want.event_kind, out_item.event_kind);
        if (out_item.column !== want.column)
          report_field("column", want.column, out_item.column);
        if (out_item.value_byte !== want.value_byte)
          report_field("value_byte", want.value_byte, out_item.value_byte);
        if (out_item.row_index !== want.row_index)
          report_field("row_index", want.row_index, out_item.row_index);
        if (out_item.limit_reached !== want.limit_reached)
          report_field("limit_reached", want.limit_reached, out_item.limit_reached);
        if (out_item.last_of_run !== want.last_of_run)
          report_field("last_of_run", want.last_of_run, out_item.last_of_run);
      end
    end
  end

  // Every task below starts and ends just after a rising edge.
  task automatic send_text(logic [7:0] b, logic eof);
    in_item_t nxt;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nxt.text_byte = b;
    nxt.end_of_file = eof;
    in_item <= nxt;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    predict_split(nxt);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DELIMITER:    cfg_delim = val[7:0];
      CFG_COLUMN_COUNT: cfg_cols = val[4:0];
      CFG_ROW_LIMIT:    cfg_row_limit = val;
      default: ;
    endcase
  endtask

  // Upper data bits of the delimiter and column-count writes are random: only their low bits count.
  task automatic set_regs(logic [7:0] delim, logic [4:0] cols, logic [31:0] limit);
    logic [31:0] w;
    w = $urandom();
    w[7:0] = delim;
    write_reg(CFG_DELIMITER, w);
    w = $urandom();
    w[4:0] = cols;
    write_reg(CFG_COLUMN_COUNT, w);
    write_reg(CFG_ROW_LIMIT, limit);
    cfg_we <= 1'b0;
  endtask

  // The block may still be busy on a byte with no result, hence the pause.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_file();
    foreach (file_text[i]) send_text(file_text[i], i == file_text.size() - 1);
    file_text.delete();
  endtask

  function logic [7:0] field_byte();
    case ($urandom_range(0, 15))
      0:       return BYTE_CR;
      1, 2:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h21, 8'h7e));
    endcase
  endfunction

  task automatic send_random_file(int unsigned lines);
    int unsigned fields;
    int unsigned len;
    for (int unsigned l = 0; l < lines; l++) begin
      case ($urandom_range(0, 9))
        0: append_text(BYTE_LF);
        1: begin
          append_text(BYTE_CR);
          append_text(BYTE_LF);
        end
        default: begin
          fields = $urandom_range(1, live_columns() + 2);
          for (int unsigned f = 0; f < fields; f++) begin
            if (f > 0) append_text(cfg_delim);
            len = $urandom_range(0, 4);
            repeat (len) append_text(field_byte());
          end
          if ($urandom_range(0, 2) == 0) append_text(BYTE_CR);
          append_text(BYTE_LF);
        end
      endcase
    end
    // About half the files have no final newline, some of them ending on a bare CR.
    if (file_text.size() > 1 && $urandom_range(0, 1) == 1) void'(file_text.pop_back());
    send_file();
  endtask

  task automatic send_noise_file();
    int unsigned len;
    len = $urandom_range(4, 30);
    repeat (len) begin
      case ($urandom_range(0, 7))
        0:       append_text(BYTE_LF);
        1:       append_text(BYTE_CR);
        default: append_text(8'($urandom_range(0, 255)));
      endcase
    end
    send_file();
  endtask

  // Reset values: comma, sixteen columns, no row limit.
  task automatic test_default_registers();
    idle_on = 1'b0;
    send_text("a", 1'b0);
    send_text(8'h00, 1'b0);
    send_text(",", 1'b0);
    send_text(8'hff, 1'b0);
    send_text(BYTE_CR, 1'b0);
    send_text(BYTE_LF, 1'b0);
    send_text(BYTE_LF, 1'b0);
    send_text(BYTE_CR, 1'b0);
    send_text("x", 1'b0);
    send_text(BYTE_CR, 1'b1);
    settle();
  endtask

  // Newline as delimiter, zero columns acting as one, and a halt after one row.
  task automatic test_newline_delimiter_and_halt();
    idle_on = 1'b1;
    set_regs(BYTE_LF, 5'd0, 32'd1);
    send_text("q", 1'b0);
    send_text(BYTE_LF, 1'b0);
    send_text("z", 1'b0);
    send_text("w", 1'b1);
    settle();
  endtask

  // A released CR that equals the delimiter splits the field.
  task automatic test_cr_as_delimiter();
    idle_on = 1'b1;
    set_regs(BYTE_CR, 5'd2, 32'hffff_ffff);
    send_text("a", 1'b0);
    send_text(BYTE_CR, 1'b0);
    send_text("b", 1'b0);
    send_text(",", 1'b0);
    send_text(BYTE_CR, 1'b0);
    send_text("c", 1'b0);
    send_text(BYTE_CR, 1'b0);
    send_text(BYTE_LF, 1'b0);
    send_text("d", 1'b1);
    settle();
  endtask

  task automatic test_random_files(int unsigned quota);
    int unsigned start;
    int unsigned phase;
    start = sent_bytes;
    phase = 0;
    while (sent_bytes - start < quota) begin
      case (phase % 5)
        0: set_regs(",", 5'd3, 32'd0);
        1: set_regs(8'h00, 5'd1, 32'd2);
        2: set_regs(8'hff, 5'd16, 32'hffff_ffff);
        3: set_regs(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                    $urandom_range(0, 4));
        default: set_regs(8'h09, 5'd31, 32'd0);
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (2) begin
        if ($urandom_range(0, 6) == 0) send_noise_file();
        else send_random_file($urandom_range(1, 3));
      end
      settle();
      phase++;
    end
  endtask

  initial begin
    reset_splitter_copy();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_newline_delimiter_and_halt();
    test_cr_as_delimiter();
    test_random_files(447);
    if (mismatch_count == 0) begin
      $display("delimited_text_field_splitter_test: done, clean");
    end else begin
      $display("delimited_text_field_splitter_test: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("delimited_text_field_splitter_test: done, errors");
    $finish;
  end

endmodule
